// ===== design/mad_pkg.sv =====
`default_nettype none
package mad_pkg;

   localparam int MAX_ITEMS = 128;
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int KEY_W     = 32;
   localparam int GAP_W     = KEY_W + 1;

   // flipping the sign bit turns signed order into unsigned order
   localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};

   // token that walks the cell chain, one cell per cycle while the row is not held
   typedef struct packed {
      logic             vld;   // token holds a request
      logic             lst;   // request closes the set
      logic             ins;   // key still has to be placed in a cell
      logic             srch;  // still looking for the insertion point
      logic             few;   // set holds fewer than two elements
      logic             ovf;   // an element of the set was dropped
      logic [KEY_W-1:0] key;   // key being inserted, or the one it displaced
      logic [GAP_W-1:0] pgap;  // gap to the largest stored key not above it
      logic [GAP_W-1:0] sgap;  // gap to the smallest stored key above it
   } tok_type;

endpackage
`default_nettype wire

// ===== design/mad_req_if.sv =====
`default_nettype none
interface mad_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic               last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface
`default_nettype wire

// ===== design/mad_rsp_if.sv =====
`default_nettype none
interface mad_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] min_diff;
   logic        too_few;
   logic        overflowed;

   modport source (output valid, output min_diff, output too_few, output overflowed,
                   input ready);
   modport sink   (input valid, input min_diff, input too_few, input overflowed,
                   output ready);
endinterface
`default_nettype wire

// ===== design/min_adjacent_difference.sv =====
// min_adjacent_difference: smallest gap between any two values of a set.
// req channel: one signed 32-bit value per request, last marks the end of
// the set. rsp channel: one result per set, sent after its last request:
// min_diff, too_few (set held under two values, min_diff all ones) and
// overflowed (values beyond 128 were dropped).
// Values are kept sorted in a row of 128 cells; each request walks the row
// one cell per cycle while the row is not held, swapping into place and
// picking up the gaps to its new neighbors; a tail stage folds those gaps
// into the running minimum. One request per cycle while req ready is high;
// a set's result passes 128 cells, one tail stage and the output register.
// A new set may start right behind the last request of the previous one.
// Reset empties all cells and the output register; the next cycle accepts
// requests. When the receiver stalls, the result waits in the output
// register and requests keep flowing; only when a second result reaches the
// tail does the whole row hold, and req ready drops until rsp is taken.
`default_nettype none
module min_adjacent_difference
   import mad_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   mad_req_if.sink   req,
   mad_rsp_if.source rsp
);

   tok_type          link [0:MAX_ITEMS];
   logic             stall;
   logic             en;
   logic             acc;
   logic             full;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] cnt_after;
   logic             ovf_ff, ovf_in;

   assign en        = !stall;
   assign req.ready = en;
   assign acc       = req.valid && en;
   assign full      = (cnt_ff == CNT_W'(MAX_ITEMS));
   assign cnt_after = full ? cnt_ff : cnt_ff + CNT_W'(1);

   always_comb begin
      link[0].vld  = acc;
      link[0].lst  = req.last;
      link[0].ins  = !full;
      link[0].srch = !full;
      link[0].few  = (cnt_after < CNT_W'(2));
      link[0].ovf  = ovf_ff || full;
      link[0].key  = $unsigned(req.value) ^ SIGN_FLIP;
      link[0].pgap = '1;
      link[0].sgap = '1;

      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (acc) begin
         if (req.last) begin
            cnt_in = '0;
            ovf_in = 1'b0;
         end else begin
            cnt_in = cnt_after;
            ovf_in = ovf_ff || full;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
   end

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      mad_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .tok_i (link[i]),
         .tok_o (link[i+1])
      );
   end

   mad_tail u_tail (
      .clock (clock),
      .reset (reset),
      .tok_i (link[MAX_ITEMS]),
      .stall (stall),
      .rsp   (rsp)
   );

endmodule
`default_nettype wire

// ===== design/mad_cell.sv =====
`default_nettype none
module mad_cell
   import mad_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    en,
   input  wire tok_type tok_i,
   output tok_type      tok_o
);

   logic [KEY_W-1:0] key_ff, key_in;
   logic             occ_ff, occ_in;
   tok_type          out_ff, out_in;

   always_comb begin
      out_in = tok_i;
      key_in = key_ff;
      occ_in = occ_ff;
      if (tok_i.vld) begin
         if (tok_i.ins) begin
            if (!occ_ff) begin
               // first free cell takes the key
               key_in      = tok_i.key;
               occ_in      = 1'b1;
               out_in.ins  = 1'b0;
               out_in.srch = 1'b0;
            end else if (tok_i.srch && (key_ff <= tok_i.key)) begin
               out_in.pgap = {1'b0, tok_i.key} - {1'b0, key_ff};
            end else begin
               // insertion point or shift: swap with the stored key
               if (tok_i.srch) begin
                  out_in.sgap = {1'b0, key_ff} - {1'b0, tok_i.key};
               end
               key_in      = tok_i.key;
               out_in.key  = key_ff;
               out_in.srch = 1'b0;
            end
         end
         // the closing request empties each cell behind it
         if (tok_i.lst) begin
            occ_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
         out_ff <= '0;
      end else if (en) begin
         occ_ff <= occ_in;
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         key_ff <= key_in;
      end
   end

   assign tok_o = out_ff;

endmodule
`default_nettype wire

// ===== design/mad_tail.sv =====
`default_nettype none
module mad_tail
   import mad_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire tok_type tok_i,
   output logic         stall,
   mad_rsp_if.source    rsp
);

   typedef struct packed {
      logic             vld;
      logic             lst;
      logic             few;
      logic             ovf;
      logic [GAP_W-1:0] gap;
   } tl_type;

   tl_type           tl_ff, tl_in;
   logic [GAP_W-1:0] run_ff, run_in;
   logic [GAP_W-1:0] nmin;
   logic             en;
   logic             take;
   logic             write;
   logic             rv_ff, rv_in;
   logic [31:0]      md_ff, md_in;
   logic             tf_ff, tf_in;
   logic             of_ff, of_in;

   assign stall = tl_ff.vld && tl_ff.lst && rv_ff && !rsp.ready;
   assign en    = !stall;

   always_comb begin
      tl_in.vld = tok_i.vld;
      tl_in.lst = tok_i.lst;
      tl_in.few = tok_i.few;
      tl_in.ovf = tok_i.ovf;
      tl_in.gap = (tok_i.pgap < tok_i.sgap) ? tok_i.pgap : tok_i.sgap;
   end

   always_comb begin
      nmin  = (tl_ff.gap < run_ff) ? tl_ff.gap : run_ff;
      take  = rv_ff && rsp.ready;
      write = en && tl_ff.vld && tl_ff.lst;
      run_in = run_ff;
      if (en && tl_ff.vld) begin
         run_in = tl_ff.lst ? '1 : nmin;
      end
      rv_in = write || (rv_ff && !take);
      md_in = md_ff;
      tf_in = tf_ff;
      of_in = of_ff;
      if (write) begin
         md_in = tl_ff.few ? '1 : nmin[31:0];
         tf_in = tl_ff.few;
         of_in = tl_ff.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tl_ff  <= '0;
         run_ff <= '1;
         rv_ff  <= 1'b0;
      end else begin
         if (en) begin
            tl_ff <= tl_in;
         end
         run_ff <= run_in;
         rv_ff  <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      md_ff <= md_in;
      tf_ff <= tf_in;
      of_ff <= of_in;
   end

   assign rsp.valid      = rv_ff;
   assign rsp.min_diff   = md_ff;
   assign rsp.too_few    = tf_ff;
   assign rsp.overflowed = of_ff;

endmodule
`default_nettype wire
